[rtl/dmaq_pkg.sv]
// Shared types, constants and helpers for the two-priority DMA request queue.
// Depends on nothing; used by dmaq_queue and two_priority_dma_request_queue.
package dmaq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = QPTR_W + 1;

    localparam int CHUNK_W     = 25;
    localparam int LEN_W       = 24;
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 8;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);
    localparam logic [CHUNK_W-1:0] CHUNK_MIN   = CHUNK_W'(32);

    localparam logic OP_POST = 1'b0;
    localparam logic OP_DONE = 1'b1;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [TAG_W-1:0]  request_tag;
        logic              to_aram;
        logic              priority_high;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic [LEN_W-1:0]  transfer_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [TAG_W-1:0]  result_tag;
        logic              dma_to_aram;
        logic [ADDR_W-1:0] main_address;
        logic [ADDR_W-1:0] aram_address;
        logic [LEN_W-1:0]  dma_length;
        logic              last_result;
    } out_item_t;

    // one queued request as held in a queue memory
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [TAG_W-1:0]  tag;
        logic              dir;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        logic push;  // write entry at tail
        logic rd;    // read head entry into the output register
        logic pop;   // retire head entry
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic out_item_t make_start(
        input logic [TAG_W-1:0]  tag,
        input logic              dir,
        input logic [ADDR_W-1:0] src,
        input logic [ADDR_W-1:0] dst,
        input logic [LEN_W-1:0]  len,
        input logic              last
    );
        out_item_t r;
        r.result_kind  = KIND_START;
        r.result_tag   = tag;
        r.dma_to_aram  = dir;
        r.main_address = dir ? src : dst;
        r.aram_address = dir ? dst : src;
        r.dma_length   = len;
        r.last_result  = last;
        return r;
    endfunction

    function automatic out_item_t make_status(
        input logic [1:0]       kind,
        input logic [TAG_W-1:0] tag,
        input logic             last
    );
        out_item_t r;
        r             = '0;
        r.result_kind = kind;
        r.result_tag  = tag;
        r.last_result = last;
        return r;
    endfunction

endpackage

[rtl/dmaq_queue.sv]
// One request FIFO: entry memory with registered read, head pointer and fill count.
// Depends on dmaq_pkg.
module dmaq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  dmaq_pkg::q_ctrl_t ctrl,
    input  dmaq_pkg::entry_t  wr_data,
    output dmaq_pkg::entry_t  rd_data,
    output dmaq_pkg::q_stat_t stat
);

    dmaq_pkg::entry_t mem [dmaq_pkg::QUEUE_DEPTH];
    dmaq_pkg::entry_t rd_data_reg;

    logic [dmaq_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [dmaq_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [dmaq_pkg::QSUM_W-1:0] tail_sum;
    logic [dmaq_pkg::QPTR_W-1:0] tail;

    always_comb
    begin
        tail_sum = dmaq_pkg::QSUM_W'(head_reg) + dmaq_pkg::QSUM_W'(count_reg);
        if (tail_sum >= dmaq_pkg::QSUM_W'(dmaq_pkg::QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - dmaq_pkg::QSUM_W'(dmaq_pkg::QUEUE_DEPTH);
        end
        tail = tail_sum[dmaq_pkg::QPTR_W-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
            if (head_reg == dmaq_pkg::QPTR_W'(dmaq_pkg::QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= wr_data;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.full  = (count_reg == dmaq_pkg::QCNT_W'(dmaq_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/two_priority_dma_request_queue.sv]
// Top level of the two-priority DMA request queue: sequencer, busy/chunk state.
// Depends on dmaq_pkg and dmaq_queue.
//
// Usage:
//   Command channel: cmd is taken when start is high and busy is low. A post
//   (operation 0) enqueues a request on the high or low queue; a dma_done
//   event (operation 1) retires the finished request and schedules the next.
//   Results: each transaction shows on result for one cycle with result_valid
//   high; the receiver cannot stall, so results are never held. An input gives
//   up to two results (completion, then DMA start); last_result marks its end.
//   Config: cfg_data (chunk size) is written when cfg_valid is high; cfg_ready
//   is always high. Values below 32 or not a multiple of 32 are dropped.
//   Timing: a post that starts nothing keeps busy low and a rejected post
//   returns its result the next cycle. Otherwise the sequencer walks
//   schedule -> queue memory read -> issue for a high-priority start and
//   schedule -> queue memory read -> low piece issue for a new low request;
//   a further low piece goes schedule -> issue, and a bare completion is
//   reported in the schedule step. The queue memory read is registered.
//   Reset: both queues empty, nothing busy, chunk size 4096. The queue
//   memories are not cleared; only occupied entries are ever read.
module two_priority_dma_request_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dmaq_pkg::in_item_t             cmd,
    output logic                           result_valid,
    output dmaq_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmaq_pkg::CHUNK_W-1:0]   cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCHED  = 3'd1;  // report completion, pick next work
    localparam logic [2:0] ST_HWAIT  = 3'd2;  // high head entry arriving
    localparam logic [2:0] ST_LWAIT  = 3'd3;  // low head entry arriving
    localparam logic [2:0] ST_LPIECE = 3'd4;  // issue one low piece

    logic [2:0] state_reg, state_next;

    dmaq_pkg::q_ctrl_t hq_ctrl, lq_ctrl;
    dmaq_pkg::q_stat_t hq_stat, lq_stat;
    dmaq_pkg::entry_t  hq_rd, lq_rd, wr_entry;

    // in-flight request bookkeeping
    logic                          high_busy_reg, high_busy_next;
    logic [dmaq_pkg::TAG_W-1:0]    high_tag_reg, high_tag_next;
    logic                          low_busy_reg, low_busy_next;
    logic                          low_final_reg, low_final_next;
    logic [dmaq_pkg::TAG_W-1:0]    low_tag_reg, low_tag_next;
    logic                          low_dir_reg, low_dir_next;
    logic [dmaq_pkg::ADDR_W-1:0]   low_src_reg, low_src_next;
    logic [dmaq_pkg::ADDR_W-1:0]   low_dst_reg, low_dst_next;
    logic [dmaq_pkg::LEN_W-1:0]    low_rem_reg, low_rem_next;

    // completion waiting to be reported in the schedule step
    logic                          comp_pend_reg, comp_pend_next;
    logic [dmaq_pkg::TAG_W-1:0]    comp_tag_reg, comp_tag_next;

    logic [dmaq_pkg::CHUNK_W-1:0]  chunk_reg, chunk_next;

    logic                          result_valid_reg, result_valid_next;
    dmaq_pkg::out_item_t           result_reg, result_next;

    logic accept;
    logic [dmaq_pkg::ADDR_W-1:0] chunk_ext;

    assign accept    = start && (state_reg == ST_IDLE);
    assign chunk_ext = dmaq_pkg::ADDR_W'(chunk_reg);

    assign wr_entry.src = cmd.source_address;
    assign wr_entry.dst = cmd.dest_address;
    assign wr_entry.tag = cmd.request_tag;
    assign wr_entry.dir = cmd.to_aram;
    assign wr_entry.len = cmd.transfer_length;

    dmaq_queue u_high_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hq_ctrl),
        .wr_data (wr_entry),
        .rd_data (hq_rd),
        .stat    (hq_stat)
    );

    dmaq_queue u_low_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lq_ctrl),
        .wr_data (wr_entry),
        .rd_data (lq_rd),
        .stat    (lq_stat)
    );

    // chunk size register; bad values are ignored
    always_comb
    begin
        chunk_next = chunk_reg;
        if (cfg_valid && (cfg_data >= dmaq_pkg::CHUNK_MIN) && (cfg_data[4:0] == '0))
        begin
            chunk_next = cfg_data;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        high_busy_next    = high_busy_reg;
        high_tag_next     = high_tag_reg;
        low_busy_next     = low_busy_reg;
        low_final_next    = low_final_reg;
        low_tag_next      = low_tag_reg;
        low_dir_next      = low_dir_reg;
        low_src_next      = low_src_reg;
        low_dst_next      = low_dst_reg;
        low_rem_next      = low_rem_reg;
        comp_pend_next    = comp_pend_reg;
        comp_tag_next     = comp_tag_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        hq_ctrl           = '0;
        lq_ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == dmaq_pkg::OP_POST)
                    begin
                        comp_pend_next = 1'b0;
                        if (cmd.priority_high ? hq_stat.full : lq_stat.full)
                        begin
                            result_valid_next = 1'b1;
                            result_next = dmaq_pkg::make_status(dmaq_pkg::KIND_REJECT,
                                                                cmd.request_tag, 1'b1);
                        end
                        else
                        begin
                            hq_ctrl.push = cmd.priority_high;
                            lq_ctrl.push = !cmd.priority_high;
                            // work only kicks off when nothing is in flight
                            if (!high_busy_reg && !low_busy_reg)
                            begin
                                state_next = ST_SCHED;
                            end
                        end
                    end
                    else
                    begin
                        // dma_done: retire high first, low only after its final piece
                        comp_pend_next = 1'b0;
                        if (high_busy_reg)
                        begin
                            comp_pend_next = 1'b1;
                            comp_tag_next  = high_tag_reg;
                            high_busy_next = 1'b0;
                            high_tag_next  = '0;
                        end
                        else if (low_busy_reg && low_final_reg)
                        begin
                            comp_pend_next = 1'b1;
                            comp_tag_next  = low_tag_reg;
                            low_busy_next  = 1'b0;
                            low_final_next = 1'b0;
                        end
                        state_next = ST_SCHED;
                    end
                end
            end

            ST_SCHED:
            begin
                if (!hq_stat.empty)
                begin
                    hq_ctrl.rd = 1'b1;
                    state_next = ST_HWAIT;
                end
                else if (!low_busy_reg && !lq_stat.empty)
                begin
                    lq_ctrl.rd = 1'b1;
                    state_next = ST_LWAIT;
                end
                else if (low_busy_reg && !low_final_reg)
                begin
                    state_next = ST_LPIECE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
                if (comp_pend_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next = dmaq_pkg::make_status(dmaq_pkg::KIND_DONE, comp_tag_reg,
                                                        state_next == ST_IDLE);
                    comp_pend_next = 1'b0;
                end
            end

            ST_HWAIT:
            begin
                hq_ctrl.pop       = 1'b1;
                high_busy_next    = 1'b1;
                high_tag_next     = hq_rd.tag;
                result_valid_next = 1'b1;
                result_next = dmaq_pkg::make_start(hq_rd.tag, hq_rd.dir, hq_rd.src,
                                                   hq_rd.dst, hq_rd.len, 1'b1);
                state_next = ST_IDLE;
            end

            ST_LWAIT:
            begin
                lq_ctrl.pop    = 1'b1;
                low_busy_next  = 1'b1;
                low_final_next = 1'b0;
                low_tag_next   = lq_rd.tag;
                low_dir_next   = lq_rd.dir;
                low_src_next   = lq_rd.src;
                low_dst_next   = lq_rd.dst;
                low_rem_next   = lq_rd.len;
                state_next     = ST_LPIECE;
            end

            ST_LPIECE:
            begin
                result_valid_next = 1'b1;
                if (dmaq_pkg::CHUNK_W'(low_rem_reg) <= chunk_reg)
                begin
                    // whole remainder goes as the final piece
                    result_next = dmaq_pkg::make_start(low_tag_reg, low_dir_reg, low_src_reg,
                                                       low_dst_reg, low_rem_reg, 1'b1);
                    low_final_next = 1'b1;
                    low_rem_next   = '0;
                end
                else
                begin
                    result_next = dmaq_pkg::make_start(low_tag_reg, low_dir_reg, low_src_reg,
                                                       low_dst_reg,
                                                       chunk_reg[dmaq_pkg::LEN_W-1:0], 1'b1);
                    low_rem_next = low_rem_reg - chunk_reg[dmaq_pkg::LEN_W-1:0];
                end
                low_src_next = low_src_reg + chunk_ext;
                low_dst_next = low_dst_reg + chunk_ext;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            high_busy_reg    <= 1'b0;
            high_tag_reg     <= '0;
            low_busy_reg     <= 1'b0;
            low_final_reg    <= 1'b0;
            low_tag_reg      <= '0;
            low_dir_reg      <= 1'b0;
            low_src_reg      <= '0;
            low_dst_reg      <= '0;
            low_rem_reg      <= '0;
            comp_pend_reg    <= 1'b0;
            comp_tag_reg     <= '0;
            chunk_reg        <= dmaq_pkg::CHUNK_RESET;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            high_busy_reg    <= high_busy_next;
            high_tag_reg     <= high_tag_next;
            low_busy_reg     <= low_busy_next;
            low_final_reg    <= low_final_next;
            low_tag_reg      <= low_tag_next;
            low_dir_reg      <= low_dir_next;
            low_src_reg      <= low_src_next;
            low_dst_reg      <= low_dst_next;
            low_rem_reg      <= low_rem_next;
            comp_pend_reg    <= comp_pend_next;
            comp_tag_reg     <= comp_tag_next;
            chunk_reg        <= chunk_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
